FILE: rtl/seed_key_access_lockout_unit_defines.svh
// ----------------------------------------------------------------------------
// Seed/key lockout assertion macros
// Shared concurrent assertion shorthands for the lockout unit.
// ----------------------------------------------------------------------------
`ifndef SEED_KEY_ACCESS_LOCKOUT_UNIT_DEFINES_SVH
`define SEED_KEY_ACCESS_LOCKOUT_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SKAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SKAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/skal_pkg.sv
// ----------------------------------------------------------------------------
// Seed/key lockout package
// Field widths, codes, reset values and shared structs.
// ----------------------------------------------------------------------------
package skal_pkg;

    localparam int OPCODE_W  = 3;
    localparam int TIME_W    = 32;
    localparam int SEED_W    = 32;
    localparam int KEY_LEN_W = 12;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int SEED_BYTES     = 4;
    localparam int SEED_BYTES_USE = (SEED_BYTES >= 4) ? 4 : SEED_BYTES;
    localparam logic [SEED_W-1:0] SEED_MASK =
        SEED_W'((64'd1 << (SEED_BYTES_USE * 8)) - 64'd1);

    localparam logic [KEY_LEN_W-1:0] MAX_KEY_BYTES = KEY_LEN_W'(64);

    localparam logic [COUNT_W-1:0] MAX_FAILURES_RST = COUNT_W'(3);
    localparam logic [TIME_W-1:0]  LOCKOUT_MS_RST   = TIME_W'(5000);
    localparam logic [COUNT_W-1:0] COUNT_SAT        = {COUNT_W{1'b1}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_REQ_SEED   = 3'd0,
        OP_SUBMIT_KEY = 3'd1,
        OP_POLL       = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_STATUS     = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 3'd0,
        ST_INVALID_ARG    = 3'd1,
        ST_DELAY_ACTIVE   = 3'd2,
        ST_NO_ENTROPY     = 3'd3,
        ST_SEQUENCE_ERROR = 3'd4,
        ST_INVALID_KEY    = 3'd5,
        ST_EXCEEDED       = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FAILURES = 2'd0,
        CFG_LOCKOUT_MS   = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [COUNT_W-1:0] max_failures;
        logic [TIME_W-1:0]  lockout_ms;
    } cfg_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [TIME_W-1:0]    now_time;
        logic [SEED_W-1:0]    fresh_seed;
        logic                 entropy_good;
        logic [KEY_LEN_W-1:0] key_length;
        logic                 key_verdict;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status_code;
        logic [SEED_W-1:0]   seed_out;
        logic                unlocked_now;
        logic [COUNT_W-1:0]  failure_count;
        logic [TIME_W-1:0]   remaining_delay;
    } result_t;

    typedef struct packed {
        logic               is_unlocked;
        logic               seed_present;
        logic [SEED_W-1:0]  stored_seed;
        logic [COUNT_W-1:0] fail_counter;
        logic [TIME_W-1:0]  lockout_deadline;
    } state_t;

endpackage

FILE: rtl/skal_ifs.sv
// ----------------------------------------------------------------------------
// Seed/key lockout channel interfaces
// Valid/ready request and response channels.
// ----------------------------------------------------------------------------
interface skal_req_if
    import skal_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [TIME_W-1:0]    now_time;
    logic [SEED_W-1:0]    fresh_seed;
    logic                 entropy_good;
    logic [KEY_LEN_W-1:0] key_length;
    logic                 key_verdict;

    modport source (
        output valid, opcode, now_time, fresh_seed, entropy_good, key_length,
               key_verdict,
        input  ready
    );
    modport sink (
        input  valid, opcode, now_time, fresh_seed, entropy_good, key_length,
               key_verdict,
        output ready
    );
endinterface

interface skal_rsp_if
    import skal_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status_code;
    logic [SEED_W-1:0]   seed_out;
    logic                unlocked_now;
    logic [COUNT_W-1:0]  failure_count;
    logic [TIME_W-1:0]   remaining_delay;

    modport source (
        output valid, status_code, seed_out, unlocked_now, failure_count,
               remaining_delay,
        input  ready
    );
    modport sink (
        input  valid, status_code, seed_out, unlocked_now, failure_count,
               remaining_delay,
        output ready
    );
endinterface

FILE: rtl/seed_key_access_lockout_unit.sv
// ----------------------------------------------------------------------------
// Seed/key access lockout unit
// Seed-and-key unlock sequencer with failure count and timed lockout.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake     | word
//   ---------+-----+---------------+-------------------------------------------
//   req      | in  | valid / ready | opcode, time, seed candidate, key info
//   rsp      | out | valid / ready | status, seed, unlock, count, delay left
//   cfg      | in  | cfg_we        | register index and write data
//
// Request accept to response valid: input register, one pass through the step
// logic, response register. One word per cycle sustained without response
// stalls. Lockout state updates when a word moves from the input to the
// response register. A stalled response holds; the input register still takes
// one word behind it. Reset clears state and loads default configuration.
// ----------------------------------------------------------------------------
`include "seed_key_access_lockout_unit_defines.svh"

module seed_key_access_lockout_unit
    import skal_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    skal_req_if.sink              req,
    skal_rsp_if.source            rsp
);

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    item_t   stg_item_reg;
    logic    stg_valid_reg;
    logic    stg_valid_next;
    result_t out_res_reg;
    result_t step_res;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    req_fire;
    logic    adv;

    skal_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    skal_step u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .item    (stg_item_reg),
        .st_next (state_next),
        .res     (step_res)
    );

    assign adv       = stg_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !stg_valid_reg || adv;
    assign req_fire  = req.valid && req.ready;

    assign stg_valid_next = req_fire ? 1'b1 : (adv ? 1'b0 : stg_valid_reg);
    assign out_valid_next = adv ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            stg_item_reg.opcode       <= req.opcode;
            stg_item_reg.now_time     <= req.now_time;
            stg_item_reg.fresh_seed   <= req.fresh_seed;
            stg_item_reg.entropy_good <= req.entropy_good;
            stg_item_reg.key_length   <= req.key_length;
            stg_item_reg.key_verdict  <= req.key_verdict;
        end
        if (adv)
            out_res_reg <= step_res;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status_code     = out_res_reg.status_code;
    assign rsp.seed_out        = out_res_reg.seed_out;
    assign rsp.unlocked_now    = out_res_reg.unlocked_now;
    assign rsp.failure_count   = out_res_reg.failure_count;
    assign rsp.remaining_delay = out_res_reg.remaining_delay;

    `SKAL_ASSERT_IMP(a_ready_only_on_full_stall, clk, rst_n, !req.ready,
        stg_valid_reg && out_valid_reg && !rsp.ready, "request blocked without full stall")

    `SKAL_ASSERT_NXT(a_state_holds_when_idle, clk, rst_n, !adv,
        $stable(state_reg), "lockout state changed with no word processed")

    `SKAL_ASSERT_NXT(a_rsp_tracks_state, clk, rst_n, adv,
        out_valid_reg && (out_res_reg.unlocked_now == state_reg.is_unlocked) &&
        (out_res_reg.failure_count == state_reg.fail_counter),
        "response word does not match updated state")

    `SKAL_ASSERT_IMP(a_dropped_seed_is_zero, clk, rst_n, !state_reg.seed_present,
        state_reg.stored_seed == '0, "stale seed kept after drop")

endmodule

FILE: rtl/skal_cfg_regs.sv
// ----------------------------------------------------------------------------
// Seed/key lockout configuration registers
// Failure limit and lockout length, written through a plain write port.
// ----------------------------------------------------------------------------
module skal_cfg_regs
    import skal_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [COUNT_W-1:0] max_failures_reg;
    logic [TIME_W-1:0]  lockout_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_failures_reg <= MAX_FAILURES_RST;
            lockout_ms_reg   <= LOCKOUT_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_FAILURES: max_failures_reg <= cfg_data[COUNT_W-1:0];
                CFG_LOCKOUT_MS:   lockout_ms_reg   <= cfg_data[TIME_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.max_failures = max_failures_reg;
    assign cfg.lockout_ms   = lockout_ms_reg;

endmodule

FILE: rtl/skal_step.sv
// ----------------------------------------------------------------------------
// Seed/key lockout step logic
// Next state and result word for one operation, purely combinational.
// ----------------------------------------------------------------------------
module skal_step
    import skal_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  st,
    input  item_t   item,
    output state_t  st_next,
    output result_t res
);

    logic [COUNT_W-1:0] limit;
    logic [TIME_W-1:0]  due_diff;
    logic               due_reached;
    logic               does_expire;
    logic [COUNT_W-1:0] fc_exp;
    logic               locked_exp;
    logic [SEED_W-1:0]  cand;
    logic [COUNT_W-1:0] fc_inc;
    logic               key_len_bad;
    logic [TIME_W-1:0]  fin_diff;
    logic               fin_locked;

    // zero limit behaves as one
    assign limit = (cfg.max_failures == '0) ? COUNT_W'(1) : cfg.max_failures;

    // wrapping time compare: reached when (now - due) is non-negative
    assign due_diff    = item.now_time - st.lockout_deadline;
    assign due_reached = !due_diff[TIME_W-1];

    assign does_expire = (item.opcode == OP_REQ_SEED || item.opcode == OP_SUBMIT_KEY ||
                          item.opcode == OP_POLL) &&
                         (st.fail_counter >= limit) && due_reached;
    assign fc_exp      = does_expire ? '0 : st.fail_counter;
    assign locked_exp  = (fc_exp >= limit);

    assign cand        = item.fresh_seed & SEED_MASK;
    assign fc_inc      = (fc_exp != COUNT_SAT) ? fc_exp + COUNT_W'(1) : fc_exp;
    assign key_len_bad = (item.key_length == '0) || (item.key_length > MAX_KEY_BYTES);

    always_comb
    begin
        st_next              = st;
        st_next.fail_counter = fc_exp;
        res.status_code      = ST_OK;
        res.seed_out         = '0;
        case (item.opcode)
            OP_REQ_SEED:
            begin
                if (locked_exp)
                    res.status_code = ST_DELAY_ACTIVE;
                else if (!st.is_unlocked)
                begin
                    st_next.stored_seed  = '0;
                    st_next.seed_present = 1'b0;
                    if (!item.entropy_good || cand == '0)
                        res.status_code = ST_NO_ENTROPY;
                    else
                    begin
                        st_next.stored_seed  = cand;
                        st_next.seed_present = 1'b1;
                        res.seed_out         = cand;
                    end
                end
            end
            OP_SUBMIT_KEY:
            begin
                if (locked_exp)
                    res.status_code = ST_DELAY_ACTIVE;
                else if (key_len_bad)
                    res.status_code = ST_INVALID_ARG;
                else if (!st.seed_present)
                    res.status_code = ST_SEQUENCE_ERROR;
                else
                begin
                    st_next.stored_seed  = '0;
                    st_next.seed_present = 1'b0;
                    if (item.key_verdict)
                    begin
                        st_next.fail_counter = '0;
                        st_next.is_unlocked  = 1'b1;
                    end
                    else
                    begin
                        st_next.fail_counter = fc_inc;
                        if (fc_inc >= limit)
                        begin
                            st_next.lockout_deadline = item.now_time + cfg.lockout_ms;
                            res.status_code          = ST_EXCEEDED;
                        end
                        else
                            res.status_code = ST_INVALID_KEY;
                    end
                end
            end
            OP_POLL:
            begin
            end
            OP_CLEAR:
            begin
                st_next.is_unlocked  = 1'b0;
                st_next.stored_seed  = '0;
                st_next.seed_present = 1'b0;
            end
            OP_STATUS:
            begin
            end
            default:
            begin
                res.status_code = ST_INVALID_ARG;
            end
        endcase

        // remaining delay is taken against the post-step deadline
        fin_diff   = item.now_time - st_next.lockout_deadline;
        fin_locked = (st_next.fail_counter >= limit);

        res.unlocked_now    = st_next.is_unlocked;
        res.failure_count   = st_next.fail_counter;
        res.remaining_delay = (fin_locked && fin_diff[TIME_W-1]) ?
                              (st_next.lockout_deadline - item.now_time) : '0;
    end

endmodule
